// ----- design/nonpenetration_motion_filter_core_macros.svh -----
// Assertion macros used by the filter top level.
`ifndef NONPENETRATION_MOTION_FILTER_CORE_MACROS_SVH
`define NONPENETRATION_MOTION_FILTER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define NMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("filter assertion failed (same cycle)");

// Check that cons holds in the cycle after ante.
`define NMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("filter assertion failed (next cycle)");

`endif

// ----- design/nmf_pkg.sv -----
// Types, constants and the operation sequence of the motion filter.
`timescale 1ns / 1ps
`default_nettype none

package nmf_pkg;

  localparam int NUM_SLOTS = 8;
  localparam logic [2:0] LAST_SLOT = 3'd7;
  localparam int OP_W = 7;
  localparam logic [OP_W-1:0] LAST_OP = 7'd65;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_EDGE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // edge vectors used as left cross operand
  typedef enum logic [1:0] {AR_E10, AR_E11, AR_F1} areg_t;
  // edge and offset vectors used as right operand
  typedef enum logic [2:0] {BR_E20, BR_E21, BR_F2, BR_P0, BR_P1} breg_t;
  // wide normal registers
  typedef enum logic [1:0] {WR_N0, WR_N1, WR_K} wreg_t;
  // sign terms
  typedef enum logic [1:0] {SG_A, SG_B, SG_P, SG_Q} sgn_t;
  // where a finished sum goes
  typedef enum logic [1:0] {DST_NONE, DST_WIDE, DST_SIGN} dst_t;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic       hi;
  } mac_ctl_t;

  typedef struct packed {
    logic       clr;
    logic       neg;
    logic       dot;
    logic       hi;
    areg_t      asel;
    logic [1:0] acomp;
    wreg_t      wsel;
    breg_t      bsel;
    logic [1:0] bcomp;
    dst_t       dst;
    wreg_t      dwide;
    sgn_t       dsign;
    logic [1:0] dcomp;
  } mop_t;

  function automatic logic [1:0] next3(logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prev3(logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // One product of a cross product component: term 0 is u[c+1]*v[c+2], term 1 is
  // u[c+2]*v[c+1] and is subtracted; sub flips the sign for the motion normal.
  function automatic mop_t xop(areg_t a, breg_t b, logic [1:0] c, logic t, logic sub,
                               logic first, logic fin, wreg_t dw);
    mop_t r;
    r       = '0;
    r.clr   = first;
    r.neg   = t ^ sub;
    r.dot   = 1'b0;
    r.asel  = a;
    r.acomp = t ? prev3(c) : next3(c);
    r.bsel  = b;
    r.bcomp = t ? next3(c) : prev3(c);
    r.dst   = fin ? DST_WIDE : DST_NONE;
    r.dwide = dw;
    r.dcomp = c;
    return r;
  endfunction

  // One half of a wide-by-narrow dot product term.
  function automatic mop_t dop(wreg_t w, breg_t b, logic [1:0] c, logic hi,
                               logic first, logic fin, sgn_t s);
    mop_t r;
    r       = '0;
    r.clr   = first;
    r.dot   = 1'b1;
    r.hi    = hi;
    r.wsel  = w;
    r.bsel  = b;
    r.bcomp = c;
    r.dst   = fin ? DST_SIGN : DST_NONE;
    r.dsign = s;
    return r;
  endfunction

  // Operation sequence: n0, n1, k = n0 + n1 - f1 x f2, then A, B, P, Q.
  function automatic mop_t mop_at(logic [OP_W-1:0] i);
    mop_t r;
    unique case (i)
      // n0 = e10 x e20
      7'd0:  r = xop(AR_E10, BR_E20, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, WR_N0);
      7'd1:  r = xop(AR_E10, BR_E20, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1, WR_N0);
      7'd2:  r = xop(AR_E10, BR_E20, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, WR_N0);
      7'd3:  r = xop(AR_E10, BR_E20, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, WR_N0);
      7'd4:  r = xop(AR_E10, BR_E20, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0, WR_N0);
      7'd5:  r = xop(AR_E10, BR_E20, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, WR_N0);
      // n1 = e11 x e21
      7'd6:  r = xop(AR_E11, BR_E21, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, WR_N1);
      7'd7:  r = xop(AR_E11, BR_E21, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1, WR_N1);
      7'd8:  r = xop(AR_E11, BR_E21, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, WR_N1);
      7'd9:  r = xop(AR_E11, BR_E21, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, WR_N1);
      7'd10: r = xop(AR_E11, BR_E21, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0, WR_N1);
      7'd11: r = xop(AR_E11, BR_E21, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, WR_N1);
      // k = n0 + n1 - f1 x f2
      7'd12: r = xop(AR_E10, BR_E20, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, WR_K);
      7'd13: r = xop(AR_E10, BR_E20, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd14: r = xop(AR_E11, BR_E21, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, WR_K);
      7'd15: r = xop(AR_E11, BR_E21, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd16: r = xop(AR_F1,  BR_F2,  2'd0, 1'b0, 1'b1, 1'b0, 1'b0, WR_K);
      7'd17: r = xop(AR_F1,  BR_F2,  2'd0, 1'b1, 1'b1, 1'b0, 1'b1, WR_K);
      7'd18: r = xop(AR_E10, BR_E20, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, WR_K);
      7'd19: r = xop(AR_E10, BR_E20, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd20: r = xop(AR_E11, BR_E21, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0, WR_K);
      7'd21: r = xop(AR_E11, BR_E21, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd22: r = xop(AR_F1,  BR_F2,  2'd1, 1'b0, 1'b1, 1'b0, 1'b0, WR_K);
      7'd23: r = xop(AR_F1,  BR_F2,  2'd1, 1'b1, 1'b1, 1'b0, 1'b1, WR_K);
      7'd24: r = xop(AR_E10, BR_E20, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0, WR_K);
      7'd25: r = xop(AR_E10, BR_E20, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd26: r = xop(AR_E11, BR_E21, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0, WR_K);
      7'd27: r = xop(AR_E11, BR_E21, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, WR_K);
      7'd28: r = xop(AR_F1,  BR_F2,  2'd2, 1'b0, 1'b1, 1'b0, 1'b0, WR_K);
      7'd29: r = xop(AR_F1,  BR_F2,  2'd2, 1'b1, 1'b1, 1'b0, 1'b1, WR_K);
      // A = n0 . p0
      7'd30: r = dop(WR_N0, BR_P0, 2'd0, 1'b1, 1'b1, 1'b0, SG_A);
      7'd31: r = dop(WR_N0, BR_P0, 2'd0, 1'b0, 1'b0, 1'b0, SG_A);
      7'd32: r = dop(WR_N0, BR_P0, 2'd1, 1'b1, 1'b0, 1'b0, SG_A);
      7'd33: r = dop(WR_N0, BR_P0, 2'd1, 1'b0, 1'b0, 1'b0, SG_A);
      7'd34: r = dop(WR_N0, BR_P0, 2'd2, 1'b1, 1'b0, 1'b0, SG_A);
      7'd35: r = dop(WR_N0, BR_P0, 2'd2, 1'b0, 1'b0, 1'b1, SG_A);
      // B = n1 . p1
      7'd36: r = dop(WR_N1, BR_P1, 2'd0, 1'b1, 1'b1, 1'b0, SG_B);
      7'd37: r = dop(WR_N1, BR_P1, 2'd0, 1'b0, 1'b0, 1'b0, SG_B);
      7'd38: r = dop(WR_N1, BR_P1, 2'd1, 1'b1, 1'b0, 1'b0, SG_B);
      7'd39: r = dop(WR_N1, BR_P1, 2'd1, 1'b0, 1'b0, 1'b0, SG_B);
      7'd40: r = dop(WR_N1, BR_P1, 2'd2, 1'b1, 1'b0, 1'b0, SG_B);
      7'd41: r = dop(WR_N1, BR_P1, 2'd2, 1'b0, 1'b0, 1'b1, SG_B);
      // P = k . p0 + n0 . p1
      7'd42: r = dop(WR_K,  BR_P0, 2'd0, 1'b1, 1'b1, 1'b0, SG_P);
      7'd43: r = dop(WR_K,  BR_P0, 2'd0, 1'b0, 1'b0, 1'b0, SG_P);
      7'd44: r = dop(WR_K,  BR_P0, 2'd1, 1'b1, 1'b0, 1'b0, SG_P);
      7'd45: r = dop(WR_K,  BR_P0, 2'd1, 1'b0, 1'b0, 1'b0, SG_P);
      7'd46: r = dop(WR_K,  BR_P0, 2'd2, 1'b1, 1'b0, 1'b0, SG_P);
      7'd47: r = dop(WR_K,  BR_P0, 2'd2, 1'b0, 1'b0, 1'b0, SG_P);
      7'd48: r = dop(WR_N0, BR_P1, 2'd0, 1'b1, 1'b0, 1'b0, SG_P);
      7'd49: r = dop(WR_N0, BR_P1, 2'd0, 1'b0, 1'b0, 1'b0, SG_P);
      7'd50: r = dop(WR_N0, BR_P1, 2'd1, 1'b1, 1'b0, 1'b0, SG_P);
      7'd51: r = dop(WR_N0, BR_P1, 2'd1, 1'b0, 1'b0, 1'b0, SG_P);
      7'd52: r = dop(WR_N0, BR_P1, 2'd2, 1'b1, 1'b0, 1'b0, SG_P);
      7'd53: r = dop(WR_N0, BR_P1, 2'd2, 1'b0, 1'b0, 1'b1, SG_P);
      // Q = k . p1 + n1 . p0
      7'd54: r = dop(WR_K,  BR_P1, 2'd0, 1'b1, 1'b1, 1'b0, SG_Q);
      7'd55: r = dop(WR_K,  BR_P1, 2'd0, 1'b0, 1'b0, 1'b0, SG_Q);
      7'd56: r = dop(WR_K,  BR_P1, 2'd1, 1'b1, 1'b0, 1'b0, SG_Q);
      7'd57: r = dop(WR_K,  BR_P1, 2'd1, 1'b0, 1'b0, 1'b0, SG_Q);
      7'd58: r = dop(WR_K,  BR_P1, 2'd2, 1'b1, 1'b0, 1'b0, SG_Q);
      7'd59: r = dop(WR_K,  BR_P1, 2'd2, 1'b0, 1'b0, 1'b0, SG_Q);
      7'd60: r = dop(WR_N1, BR_P0, 2'd0, 1'b1, 1'b0, 1'b0, SG_Q);
      7'd61: r = dop(WR_N1, BR_P0, 2'd0, 1'b0, 1'b0, 1'b0, SG_Q);
      7'd62: r = dop(WR_N1, BR_P0, 2'd1, 1'b1, 1'b0, 1'b0, SG_Q);
      7'd63: r = dop(WR_N1, BR_P0, 2'd1, 1'b0, 1'b0, 1'b0, SG_Q);
      7'd64: r = dop(WR_N1, BR_P0, 2'd2, 1'b1, 1'b0, 1'b0, SG_Q);
      7'd65: r = dop(WR_N1, BR_P0, 2'd2, 1'b0, 1'b0, 1'b1, SG_Q);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/nmf_mac.sv -----
// Shared multiply-accumulate unit: registered product, shifted for the high half, then added or subtracted.
`timescale 1ns / 1ps
`default_nettype none

module nmf_mac
  import nmf_pkg::*;
#(
  parameter int MW    = 20,
  parameter int SHIFT = 19,
  parameter int ACC_W = 60
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctl_t                ctl,
  input  wire logic signed [MW-1:0]    op_a,
  input  wire logic signed [MW-1:0]    op_b,
  output logic signed [ACC_W-1:0]      sum,
  output logic                         sum_vld
);

  localparam int PW = 2 * MW;

  logic signed [PW-1:0]    prod_r;
  mac_ctl_t                ctl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] ext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;

  // Register the product and its control.
  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  // Align the product to its half and fold it into the running sum.
  always_comb begin
    ext  = ACC_W'(prod_r);
    term = ctl_r.hi ? (ext <<< SHIFT) : ext;
    base = ctl_r.clr ? '0 : acc_r;
    sum  = ctl_r.neg ? (base - term) : (base + term);
  end

  assign sum_vld = ctl_r.vld;

  // Hold the sum between beats of the sequence.
  always_ff @(posedge clk) begin
    if (ctl_r.vld) begin
      acc_r <= sum;
    end
  end

endmodule

`default_nettype wire

// ----- design/nonpenetration_motion_filter_core.sv -----
// Top level of the non-penetration motion filter: point store, sequencer and datapath.
// Beats for slots 0..6 only store a point; a slot 7 beat starts the sequence and raises
//   out_strobe once the result is ready, and busy drops the cycle after that.
// Busy holds after a slot 7 beat through 8 differences, 1 edge step, 66 shared
//   multiply-accumulate passes, 1 drain and 1 result; no beat is accepted while busy.
// Reset (synchronous, active low) clears the sequencer and marks all stored points zero.
`timescale 1ns / 1ps
`default_nettype none
`include "nonpenetration_motion_filter_core_macros.svh"

module nonpenetration_motion_filter_core
  import nmf_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   in_point_slot,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  input  wire logic signed [COORD_BITS-1:0] in_coord_z,
  output logic                              out_strobe,
  output logic                              out_may_collide
);

  localparam int W     = COORD_BITS;
  localparam int DW    = W + 2;          // edge, offset and motion edge width
  localparam int NW    = 2 * W + 6;      // normal width
  localparam int LW    = W + 3;          // low part of a split normal
  localparam int MW    = W + 4;          // multiplier operand width
  localparam int ACC_W = 3 * W + 12;     // sum width

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   cnt_r, cnt_nxt;
  logic              acc_in;

  // point store
  logic signed [W-1:0] px_r [NUM_SLOTS];
  logic signed [W-1:0] py_r [NUM_SLOTS];
  logic signed [W-1:0] pz_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pvld_r;
  logic [2:0]           rd_slot;
  logic signed [W-1:0]  rd_p [3];
  logic signed [W-1:0]  base_r [3];
  logic signed [DW-1:0] dif [3];

  // edge and offset vectors
  logic signed [DW-1:0] e10_r [3];
  logic signed [DW-1:0] e11_r [3];
  logic signed [DW-1:0] f1_r  [3];
  logic signed [DW-1:0] e20_r [3];
  logic signed [DW-1:0] e21_r [3];
  logic signed [DW-1:0] f2_r  [3];
  logic signed [DW-1:0] p0_r  [3];
  logic signed [DW-1:0] p1_r  [3];

  // normals
  logic signed [NW-1:0] n0_r [3];
  logic signed [NW-1:0] n1_r [3];
  logic signed [NW-1:0] k_r  [3];

  // operation issue and result
  mop_t                    op;
  mop_t                    op_d_r;
  mac_ctl_t                mctl;
  logic signed [DW-1:0]    a_v [3];
  logic signed [DW-1:0]    b_v [3];
  logic signed [NW-1:0]    w_v [3];
  logic signed [DW-1:0]    a_n;
  logic signed [DW-1:0]    b_n;
  logic signed [NW-1:0]    w_c;
  logic signed [MW-1:0]    op_a;
  logic signed [MW-1:0]    op_b;
  logic signed [ACC_W-1:0] sum;
  logic                    sum_vld;
  logic [3:0]              pos_r;
  logic [3:0]              neg_r;

  assign busy   = (state_r != ST_IDLE);
  assign acc_in = start && !busy;

  // Store each accepted point and mark its slot written.
  always_ff @(posedge clk) begin
    if (acc_in) begin
      px_r[in_point_slot] <= in_coord_x;
      py_r[in_point_slot] <= in_coord_y;
      pz_r[in_point_slot] <= in_coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
    end else if (acc_in) begin
      pvld_r[in_point_slot] <= 1'b1;
    end
  end

  // Read one slot a cycle; an unwritten slot reads as zero.
  always_comb begin
    rd_slot = cnt_r[2:0];
    rd_p[0] = pvld_r[rd_slot] ? px_r[rd_slot] : '0;
    rd_p[1] = pvld_r[rd_slot] ? py_r[rd_slot] : '0;
    rd_p[2] = pvld_r[rd_slot] ? pz_r[rd_slot] : '0;
    for (int j = 0; j < 3; j++) begin
      dif[j] = DW'(rd_p[j]) - DW'(base_r[j]);
    end
  end

  // Form edges and offsets against the held a point, then the motion edges.
  always_ff @(posedge clk) begin
    if (state_r == ST_DIFF) begin
      unique case (rd_slot)
        3'd0, 3'd4: base_r <= rd_p;
        3'd1:       e10_r  <= dif;
        3'd2:       e20_r  <= dif;
        3'd3:       p0_r   <= dif;
        3'd5:       e11_r  <= dif;
        3'd6:       e21_r  <= dif;
        default:    p1_r   <= dif;
      endcase
    end else if (state_r == ST_EDGE) begin
      for (int j = 0; j < 3; j++) begin
        f1_r[j] <= e11_r[j] - e10_r[j];
        f2_r[j] <= e21_r[j] - e20_r[j];
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc_in && (in_point_slot == LAST_SLOT)) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = ST_EDGE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EDGE: begin
        state_nxt = ST_MAC;
        cnt_nxt   = '0;
      end
      ST_MAC: begin
        if (cnt_r == LAST_OP) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Decode the current operation and steer its operands.
  always_comb begin
    op = mop_at(cnt_r);

    unique case (op.asel)
      AR_E10:  a_v = e10_r;
      AR_E11:  a_v = e11_r;
      default: a_v = f1_r;
    endcase
    unique case (op.bsel)
      BR_E20:  b_v = e20_r;
      BR_E21:  b_v = e21_r;
      BR_F2:   b_v = f2_r;
      BR_P0:   b_v = p0_r;
      default: b_v = p1_r;
    endcase
    unique case (op.wsel)
      WR_N0:   w_v = n0_r;
      WR_N1:   w_v = n1_r;
      default: w_v = k_r;
    endcase

    unique case (op.acomp)
      2'd0:    a_n = a_v[0];
      2'd1:    a_n = a_v[1];
      default: a_n = a_v[2];
    endcase
    unique case (op.bcomp)
      2'd0: begin
        b_n = b_v[0];
        w_c = w_v[0];
      end
      2'd1: begin
        b_n = b_v[1];
        w_c = w_v[1];
      end
      default: begin
        b_n = b_v[2];
        w_c = w_v[2];
      end
    endcase

    // split a normal into a signed upper part and an unsigned lower part
    if (op.dot) begin
      op_a = op.hi ? MW'($signed(w_c[NW-1:LW])) : MW'($signed({1'b0, w_c[LW-1:0]}));
    end else begin
      op_a = MW'(a_n);
    end
    op_b = MW'(b_n);

    mctl.vld = (state_r == ST_MAC);
    mctl.clr = op.clr;
    mctl.neg = op.neg;
    mctl.hi  = op.dot && op.hi;
  end

  nmf_mac #(
    .MW    (MW),
    .SHIFT (LW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .sum     (sum),
    .sum_vld (sum_vld)
  );

  // Track the destination of the operation now in the accumulate stage.
  always_ff @(posedge clk) begin
    op_d_r <= op;
  end

  // Write finished normals.
  always_ff @(posedge clk) begin
    if (sum_vld && (op_d_r.dst == DST_WIDE)) begin
      for (int j = 0; j < 3; j++) begin
        if (op_d_r.dcomp == 2'(j)) begin
          unique case (op_d_r.dwide)
            WR_N0:   n0_r[j] <= NW'(sum);
            WR_N1:   n1_r[j] <= NW'(sum);
            default: k_r[j]  <= NW'(sum);
          endcase
        end
      end
    end
  end

  // Capture the sign of each finished term.
  always_ff @(posedge clk) begin
    if (sum_vld && (op_d_r.dst == DST_SIGN)) begin
      neg_r[op_d_r.dsign] <= sum[ACC_W-1];
      pos_r[op_d_r.dsign] <= !sum[ACC_W-1] && (sum != '0);
    end
  end

  // Present the result beat.
  assign out_strobe      = (state_r == ST_DONE);
  assign out_may_collide = !((&pos_r) || (&neg_r));

  `NMF_ASSERT_NEXT(a_short_load, clk, rst_n, acc_in && (in_point_slot != LAST_SLOT), !busy)
  `NMF_ASSERT_NEXT(a_last_load, clk, rst_n, acc_in && (in_point_slot == LAST_SLOT), busy && !out_strobe)
  `NMF_ASSERT_NEXT(a_one_result, clk, rst_n, out_strobe, !out_strobe && !busy)
  `NMF_ASSERT_SAME(a_sum_window, clk, rst_n, sum_vld, (state_r == ST_MAC) || (state_r == ST_DRAIN))

endmodule

`default_nettype wire
